### sv/rieu_pkg.sv
package rieu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned NREG = 32;
	localparam int unsigned RIDX = 5;
	localparam logic [XLEN-1:0] MEM_TOP_RESET = '1;

	// Configuration register indexes
	localparam logic CFG_START_PC   = 1'b0;
	localparam logic CFG_MEMORY_TOP = 1'b1;

	// Result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_LOAD    = 3'd1;
	localparam logic [2:0] ST_BREAK   = 3'd2;
	localparam logic [2:0] ST_TRAP    = 3'd3;
	localparam logic [2:0] ST_UNSUP   = 3'd4;
	localparam logic [2:0] ST_SYSCALL = 3'd5;
	localparam logic [2:0] ST_HALTED  = 3'd6;
	localparam logic [2:0] ST_ORDER   = 3'd7;

	// Memory access kinds and sizes
	localparam logic [1:0] MK_NONE  = 2'd0;
	localparam logic [1:0] MK_LOAD  = 2'd1;
	localparam logic [1:0] MK_STORE = 2'd2;
	localparam logic [1:0] MS_BYTE  = 2'd0;
	localparam logic [1:0] MS_HALF  = 2'd1;
	localparam logic [1:0] MS_WORD  = 2'd2;

	// Pending load kinds
	localparam logic [2:0] LK_LB  = 3'd0;
	localparam logic [2:0] LK_LH  = 3'd1;
	localparam logic [2:0] LK_LW  = 3'd2;
	localparam logic [2:0] LK_LBU = 3'd3;
	localparam logic [2:0] LK_LHU = 3'd4;

	// Opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_REGIMM = 6'h01;
	localparam logic [5:0] OP_J    = 6'h02;
	localparam logic [5:0] OP_JAL  = 6'h03;
	localparam logic [5:0] OP_BEQ  = 6'h04;
	localparam logic [5:0] OP_BNE  = 6'h05;
	localparam logic [5:0] OP_BLEZ = 6'h06;
	localparam logic [5:0] OP_BGTZ = 6'h07;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI = 6'h0C;
	localparam logic [5:0] OP_ORI  = 6'h0D;
	localparam logic [5:0] OP_XORI = 6'h0E;
	localparam logic [5:0] OP_LUI  = 6'h0F;
	localparam logic [5:0] OP_LLO  = 6'h18;
	localparam logic [5:0] OP_LHI  = 6'h19;
	localparam logic [5:0] OP_TRAP = 6'h1A;
	localparam logic [5:0] OP_LB   = 6'h20;
	localparam logic [5:0] OP_LH   = 6'h21;
	localparam logic [5:0] OP_LW   = 6'h23;
	localparam logic [5:0] OP_LBU  = 6'h24;
	localparam logic [5:0] OP_LHU  = 6'h25;
	localparam logic [5:0] OP_SB   = 6'h28;
	localparam logic [5:0] OP_SH   = 6'h29;
	localparam logic [5:0] OP_SW   = 6'h2B;

	// R-type function codes
	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_BREAK = 6'h0D;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MTHI = 6'h11;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MTLO = 6'h13;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV  = 6'h1A;
	localparam logic [5:0] FN_DIVU = 6'h1B;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	// REGIMM rt codes
	localparam logic [4:0] RI_BLTZ = 5'h00;
	localparam logic [4:0] RI_BGEZ = 5'h01;
	localparam logic [4:0] RI_BLTZAL = 5'h10;
	localparam logic [4:0] RI_BGEZAL = 5'h11;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_WB,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [XLEN-1:0] next_pc;
		logic [1:0]      mem_kind;
		logic [XLEN-1:0] mem_addr;
		logic [1:0]      mem_size;
		logic [XLEN-1:0] store_data;
		logic            wb_valid;
		logic [RIDX-1:0] wb_reg;
		logic [XLEN-1:0] wb_value;
		logic [2:0]      status;
		logic [XLEN-1:0] syscall_service;
		logic [XLEN-1:0] syscall_arg;
	} result_t;

	typedef struct packed {
		logic            func;
		logic [XLEN-1:0] instr;
		logic [XLEN-1:0] load_word;
	} item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic div_step;
		logic writeback;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_start;
		logic div_done;
	} sts_t;

endpackage

### sv/rieu_if.sv
interface rieu_in_if;
	import rieu_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rieu_out_if;
	import rieu_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/rieu_divider.sv
module rieu_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic step,
	input  logic [rieu_pkg::XLEN-1:0] dividend,
	input  logic [rieu_pkg::XLEN-1:0] divisor,
	output logic done,
	output logic [rieu_pkg::XLEN-1:0] quotient,
	output logic [rieu_pkg::XLEN-1:0] remainder
);
	import rieu_pkg::*;

	localparam int unsigned CW = $clog2(XLEN + 1);

	logic [XLEN-1:0] rem_q, quo_q, dsr_q;
	logic [CW-1:0]   cnt_q;
	logic [XLEN:0]   trial;
	logic [XLEN:0]   shifted;

	// One quotient bit per step, restoring form
	always_comb begin
		shifted = {rem_q, quo_q[XLEN-1]};
		trial   = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(XLEN);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (step && cnt_q != '0) begin
			if (!trial[XLEN]) begin
				rem_q <= trial[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= shifted[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b0};
			end
		end
	end

	assign done      = (cnt_q == '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### sv/rieu_datapath.sv
module rieu_datapath (
	input  logic clk,
	input  logic arst_n,
	input  rieu_pkg::cmd_t cmd,
	output rieu_pkg::sts_t sts,
	input  rieu_pkg::item_t item,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [rieu_pkg::XLEN-1:0] cfg_data,
	output rieu_pkg::result_t result
);
	import rieu_pkg::*;

	logic [XLEN-1:0] regs_q [NREG];
	logic [XLEN-1:0] hi_q, lo_q, pc_q, top_q;
	logic            halted_q, pend_q;
	logic [RIDX-1:0] pend_dest_q;
	logic [2:0]      pend_kind_q;
	item_t           item_q;
	logic [XLEN-1:0] a_q, b_q, v0_q, a0_q, pcn_q;
	logic [2*XLEN-1:0] prod_q;
	logic            is_mul_q, is_div_q, div_neg_q, rem_neg_q;
	result_t         res_q;

	// Decoded fields of the captured instruction
	logic [5:0] op, fn;
	logic [4:0] rs, rt, rd, sh;
	logic [XLEN-1:0] imm, simm, btgt, jtgt, addr;
	logic [XLEN:0]   pc_sum;

	assign op   = item_q.instr[31:26];
	assign rs   = item_q.instr[25:21];
	assign rt   = item_q.instr[20:16];
	assign rd   = item_q.instr[15:11];
	assign sh   = item_q.instr[10:6];
	assign fn   = item_q.instr[5:0];
	assign imm  = {16'b0, item_q.instr[15:0]};
	assign simm = {{16{item_q.instr[15]}}, item_q.instr[15:0]};
	assign btgt = pcn_q + {simm[29:0], 2'b00};
	assign jtgt = {pcn_q[31:28], item_q.instr[25:0], 2'b00};
	assign addr = a_q + simm;
	assign pc_sum = {1'b0, pc_q} + (XLEN+1)'(4);

	// Divider operands are magnitudes
	logic [XLEN-1:0] div_a, div_b, quo, rem;
	logic sgn_div;
	logic div_start, div_done;
	assign sgn_div = (fn == FN_DIV);
	assign div_a = (sgn_div && a_q[31]) ? (32'd0 - a_q) : a_q;
	assign div_b = (sgn_div && b_q[31]) ? (32'd0 - b_q) : b_q;

	rieu_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start && cmd.exec),
		.step      (cmd.div_step),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign div_start = !item_q.func && !halted_q && !pend_q && op == OP_RTYPE
		&& (fn == FN_DIV || fn == FN_DIVU) && item_q.instr != '0;
	assign sts = '{div_start: div_start, div_done: div_done};

	// One 33 by 33 signed multiplier serves both MULT and MULTU
	logic sgn_mul;
	logic signed [XLEN:0]     mul_a, mul_b;
	logic signed [2*XLEN+1:0] mul_p;
	assign sgn_mul = (fn == FN_MULT);
	assign mul_a = {sgn_mul && a_q[31], a_q};
	assign mul_b = {sgn_mul && b_q[31], b_q};
	assign mul_p = mul_a * mul_b;

	// Capture, register read, multiply and divide flags
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.read) begin
			a_q   <= regs_q[rs];
			b_q   <= regs_q[rt];
			v0_q  <= regs_q[2];
			a0_q  <= regs_q[4];
			pcn_q <= (pc_sum > {1'b0, top_q}) ? '0 : pc_sum[XLEN-1:0];
		end
		if (cmd.exec) begin
			prod_q    <= mul_p[2*XLEN-1:0];
			is_mul_q  <= (fn == FN_MULT || fn == FN_MULTU);
			is_div_q  <= div_start && b_q != '0;
			div_neg_q <= sgn_div && (a_q[31] != b_q[31]);
			rem_neg_q <= sgn_div && a_q[31];
		end
	end

	// Execute and state update, in the writeback step
	result_t r;
	logic [XLEN-1:0] pc_n, hi_n, lo_n;
	logic halt_n, pend_n;
	logic [RIDX-1:0] pdest_n;
	logic [2:0] pkind_n;
	logic wr;
	logic [RIDX-1:0] wr_idx;
	logic [XLEN-1:0] wr_val, ld_v;
	logic neg;

	always_comb begin
		r = '0;
		pc_n = pc_q; hi_n = hi_q; lo_n = lo_q;
		halt_n = halted_q; pend_n = pend_q; pdest_n = pend_dest_q; pkind_n = pend_kind_q;
		wr = 1'b0; wr_idx = '0; wr_val = '0; ld_v = item_q.load_word;
		neg = a_q[31];
		r.status = ST_OK;
		if (halted_q) begin
			r.status = ST_HALTED;
		end else if (item_q.func) begin
			if (!pend_q) begin
				r.status = ST_ORDER;
			end else begin
				unique case (pend_kind_q)
					LK_LB:  ld_v = {{24{item_q.load_word[31]}}, item_q.load_word[31:24]};
					LK_LH:  ld_v = {{16{item_q.load_word[31]}}, item_q.load_word[31:16]};
					LK_LBU: ld_v = {24'b0, item_q.load_word[31:24]};
					LK_LHU: ld_v = {16'b0, item_q.load_word[31:16]};
					default: ld_v = item_q.load_word;
				endcase
				pend_n = 1'b0;
				wr = 1'b1; wr_idx = pend_dest_q; wr_val = ld_v;
			end
		end else if (pend_q) begin
			r.status = ST_ORDER;
		end else begin
			pc_n = pcn_q;
			if (item_q.instr != '0) begin
				unique case (op)
					OP_RTYPE: begin
						unique case (fn)
							FN_SLL:  begin wr = 1'b1; wr_idx = rd; wr_val = b_q << sh; end
							FN_SRL:  begin wr = 1'b1; wr_idx = rd; wr_val = b_q >> sh; end
							FN_SRA:  begin wr = 1'b1; wr_idx = rd; wr_val = $signed(b_q) >>> sh; end
							FN_SLLV: begin wr = 1'b1; wr_idx = rd; wr_val = b_q << a_q[4:0]; end
							FN_SRLV: begin wr = 1'b1; wr_idx = rd; wr_val = b_q >> a_q[4:0]; end
							FN_SRAV: begin wr = 1'b1; wr_idx = rd; wr_val = $signed(b_q) >>> a_q[4:0]; end
							FN_JR:   pc_n = a_q;
							FN_JALR: begin pc_n = a_q; wr = 1'b1; wr_idx = rd; wr_val = pcn_q; end
							FN_SYSCALL: begin
								r.status = ST_SYSCALL;
								r.syscall_service = v0_q;
								r.syscall_arg = a0_q;
							end
							FN_BREAK: begin r.status = ST_BREAK; halt_n = 1'b1; end
							FN_MFHI: begin wr = 1'b1; wr_idx = rd; wr_val = hi_q; end
							FN_MTHI: hi_n = a_q;
							FN_MFLO: begin wr = 1'b1; wr_idx = rd; wr_val = lo_q; end
							FN_MTLO: lo_n = a_q;
							FN_MULT, FN_MULTU: begin
								hi_n = prod_q[2*XLEN-1:XLEN]; lo_n = prod_q[XLEN-1:0];
							end
							FN_DIV, FN_DIVU: begin
								if (is_div_q) begin
									lo_n = div_neg_q ? (32'd0 - quo) : quo;
									hi_n = rem_neg_q ? (32'd0 - rem) : rem;
								end
							end
							FN_ADD, FN_ADDU: begin wr = 1'b1; wr_idx = rd; wr_val = a_q + b_q; end
							FN_SUB, FN_SUBU: begin wr = 1'b1; wr_idx = rd; wr_val = a_q - b_q; end
							FN_AND: begin wr = 1'b1; wr_idx = rd; wr_val = a_q & b_q; end
							FN_OR:  begin wr = 1'b1; wr_idx = rd; wr_val = a_q | b_q; end
							FN_XOR: begin wr = 1'b1; wr_idx = rd; wr_val = a_q ^ b_q; end
							FN_NOR: begin wr = 1'b1; wr_idx = rd; wr_val = ~(a_q | b_q); end
							FN_SLT: begin
								wr = 1'b1; wr_idx = rd;
								wr_val = {31'b0, $signed(a_q) < $signed(b_q)};
							end
							FN_SLTU: begin wr = 1'b1; wr_idx = rd; wr_val = {31'b0, a_q < b_q}; end
							default: begin r.status = ST_UNSUP; halt_n = 1'b1; end
						endcase
					end
					OP_REGIMM: begin
						unique case (rt)
							RI_BLTZ: if (neg) pc_n = btgt;
							RI_BGEZ: if (!neg) pc_n = btgt;
							RI_BLTZAL: begin
								if (neg) pc_n = btgt;
								wr = 1'b1; wr_idx = 5'd31; wr_val = pcn_q;
							end
							RI_BGEZAL: begin
								if (!neg) pc_n = btgt;
								wr = 1'b1; wr_idx = 5'd31; wr_val = pcn_q;
							end
							default: begin r.status = ST_UNSUP; halt_n = 1'b1; end
						endcase
					end
					OP_J:   pc_n = jtgt;
					OP_JAL: begin pc_n = jtgt; wr = 1'b1; wr_idx = 5'd31; wr_val = pcn_q; end
					OP_BEQ:  if (a_q == b_q) pc_n = btgt;
					OP_BNE:  if (a_q != b_q) pc_n = btgt;
					OP_BLEZ: if (neg || a_q == '0) pc_n = btgt;
					OP_BGTZ: if (!neg && a_q != '0) pc_n = btgt;
					OP_ADDI, OP_ADDIU: begin wr = 1'b1; wr_idx = rt; wr_val = a_q + simm; end
					OP_SLTI: begin
						wr = 1'b1; wr_idx = rt; wr_val = {31'b0, $signed(a_q) < $signed(simm)};
					end
					OP_SLTIU: begin wr = 1'b1; wr_idx = rt; wr_val = {31'b0, a_q < simm}; end
					OP_ANDI: begin wr = 1'b1; wr_idx = rt; wr_val = a_q & imm; end
					OP_ORI:  begin wr = 1'b1; wr_idx = rt; wr_val = a_q | imm; end
					OP_XORI: begin wr = 1'b1; wr_idx = rt; wr_val = a_q ^ imm; end
					OP_LUI:  begin wr = 1'b1; wr_idx = rt; wr_val = {imm[15:0], 16'b0}; end
					OP_LLO:  begin wr = 1'b1; wr_idx = rt; wr_val = {b_q[31:16], imm[15:0]}; end
					OP_LHI:  begin wr = 1'b1; wr_idx = rt; wr_val = {imm[15:0], b_q[15:0]}; end
					OP_TRAP: begin r.status = ST_TRAP; halt_n = 1'b1; end
					OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
						pend_n = 1'b1; pdest_n = rt;
						priority case (op)
							OP_LB:  pkind_n = LK_LB;
							OP_LH:  pkind_n = LK_LH;
							OP_LW:  pkind_n = LK_LW;
							OP_LBU: pkind_n = LK_LBU;
							default: pkind_n = LK_LHU;
						endcase
						r.mem_kind = MK_LOAD; r.mem_addr = addr;
						r.mem_size = (pkind_n == LK_LW) ? MS_WORD
							: (pkind_n == LK_LH || pkind_n == LK_LHU) ? MS_HALF : MS_BYTE;
						r.status = ST_LOAD;
					end
					OP_SB: begin
						r.mem_kind = MK_STORE; r.mem_addr = addr; r.mem_size = MS_BYTE;
						r.store_data = {24'b0, b_q[7:0]};
					end
					OP_SH: begin
						r.mem_kind = MK_STORE; r.mem_addr = addr; r.mem_size = MS_HALF;
						r.store_data = {16'b0, b_q[15:0]};
					end
					OP_SW: begin
						r.mem_kind = MK_STORE; r.mem_addr = addr; r.mem_size = MS_WORD;
						r.store_data = b_q;
					end
					default: begin r.status = ST_UNSUP; halt_n = 1'b1; end
				endcase
			end
		end
		// Writes to r0 are dropped
		if (wr && wr_idx != '0) begin
			r.wb_valid = 1'b1; r.wb_reg = wr_idx; r.wb_value = wr_val;
		end
		r.next_pc = pc_n;
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) regs_q[i] <= '0;
			hi_q <= '0; lo_q <= '0; pc_q <= '0; top_q <= MEM_TOP_RESET;
			halted_q <= 1'b0; pend_q <= 1'b0; pend_dest_q <= '0; pend_kind_q <= LK_LB;
		end else begin
			if (cmd.writeback) begin
				if (r.wb_valid) regs_q[r.wb_reg] <= r.wb_value;
				hi_q <= hi_n; lo_q <= lo_n; pc_q <= pc_n;
				halted_q <= halt_n; pend_q <= pend_n;
				pend_dest_q <= pdest_n; pend_kind_q <= pkind_n;
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_START_PC) pc_q <= cfg_data;
				else top_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.writeback) res_q <= r;
	end

	assign result = res_q;

endmodule

### sv/rieu_control.sv
module rieu_control (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  rieu_pkg::sts_t sts,
	output rieu_pkg::cmd_t cmd
);
	import rieu_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_n = S_READ;
			S_READ: state_n = S_EXEC;
			S_EXEC: state_n = sts.div_start ? S_DIV : S_WB;
			S_DIV:  if (sts.div_done) state_n = S_WB;
			S_WB:   state_n = S_OUT;
			S_OUT: begin
				if (out_ready) state_n = in_valid ? S_READ : S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Outputs; the result register holds while the next item is read
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin in_ready = 1'b1; cmd.capture = in_valid; end
			S_READ: cmd.read = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_WB:   cmd.writeback = 1'b1;
			S_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				cmd.capture = out_ready && in_valid;
			end
			default: ;
		endcase
	end

endmodule

### sv/risc_integer_execute_unit_top.sv
// Each item passes through the read, execute and writeback states before the
// result is offered; DIV and DIVU add a divide state, where a shared
// one-bit-per-cycle divider iterates whatever the divisor.
// A new item is taken only while idle or once the previous result is taken.
// Reset (arst_n low) clears registers, hi, lo, PC, halt and pending load at once;
// memory_top resets to all ones.
module risc_integer_execute_unit_top (
	input  logic clk,
	input  logic arst_n,
	rieu_in_if.sink    in_ch,
	rieu_out_if.source out_ch,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [rieu_pkg::XLEN-1:0] cfg_data
);
	import rieu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rieu_control u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rieu_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (in_ch.data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.result   (out_ch.data)
	);

endmodule

### tb/rieu_checker.sv
// Watches both channels and the configuration port, predicts every result from
// its own copy of the architectural state and compares each result transfer.
module rieu_checker (
	input  logic        clk,
	input  logic        arst_n,
	rieu_in_if          in_ch,
	rieu_out_if         out_ch,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          outstanding
);
	import rieu_pkg::*;

	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, pc_q, top_q;
	logic        halted_q, load_pend_q;
	logic [4:0]  load_dest_q;
	logic [2:0]  load_kind_q;
	result_t     expected_results [$];

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Executes one item against the shadow state and returns the expected result.
	function automatic result_t execute_item(item_t it);
		result_t     r;
		logic [32:0] sum;
		logic [31:0] pcn, a, b, imm, simm, btgt, addr, v, ma, mb, q, rm;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sh;
		logic        wen, na, nb;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic [63:0] p;
		r = '0;
		wen = 1'b0;
		widx = '0;
		wval = '0;
		if (halted_q) begin
			r.status = ST_HALTED;
		end else if (it.func) begin
			if (!load_pend_q) begin
				r.status = ST_ORDER;
			end else begin
				case (load_kind_q)
					LK_LB:   v = {{24{it.load_word[31]}}, it.load_word[31:24]};
					LK_LH:   v = sext16(it.load_word[31:16]);
					LK_LBU:  v = {24'b0, it.load_word[31:24]};
					LK_LHU:  v = {16'b0, it.load_word[31:16]};
					default: v = it.load_word;
				endcase
				load_pend_q = 1'b0;
				wen = 1'b1; widx = load_dest_q; wval = v;
			end
		end else if (load_pend_q) begin
			r.status = ST_ORDER;
		end else begin
			sum = {1'b0, pc_q} + 33'd4;
			pcn = (sum > {1'b0, top_q}) ? 32'd0 : sum[31:0];
			pc_q = pcn;
			op = it.instr[31:26]; rs = it.instr[25:21]; rt = it.instr[20:16];
			rd = it.instr[15:11]; sh = it.instr[10:6]; fn = it.instr[5:0];
			a = gpr[rs]; b = gpr[rt];
			imm = {16'b0, it.instr[15:0]};
			simm = sext16(it.instr[15:0]);
			btgt = pcn + (simm << 2);
			addr = a + simm;
			if (it.instr != '0) begin
				case (op)
					OP_RTYPE: begin
						case (fn)
							FN_SLL:  begin wen = 1; widx = rd; wval = b << sh; end
							FN_SRL:  begin wen = 1; widx = rd; wval = b >> sh; end
							FN_SRA:  begin wen = 1; widx = rd; wval = $signed(b) >>> sh; end
							FN_SLLV: begin wen = 1; widx = rd; wval = b << a[4:0]; end
							FN_SRLV: begin wen = 1; widx = rd; wval = b >> a[4:0]; end
							FN_SRAV: begin wen = 1; widx = rd; wval = $signed(b) >>> a[4:0]; end
							FN_JR:   pc_q = a;
							FN_JALR: begin pc_q = a; wen = 1; widx = rd; wval = pcn; end
							FN_SYSCALL: begin
								r.status = ST_SYSCALL;
								r.syscall_service = gpr[2];
								r.syscall_arg = gpr[4];
							end
							FN_BREAK: begin r.status = ST_BREAK; halted_q = 1'b1; end
							FN_MFHI: begin wen = 1; widx = rd; wval = hi_q; end
							FN_MTHI: hi_q = a;
							FN_MFLO: begin wen = 1; widx = rd; wval = lo_q; end
							FN_MTLO: lo_q = a;
							FN_MULT: begin
								p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
								hi_q = p[63:32]; lo_q = p[31:0];
							end
							FN_MULTU: begin
								p = {32'b0, a} * {32'b0, b};
								hi_q = p[63:32]; lo_q = p[31:0];
							end
							FN_DIV: if (b != 0) begin
								na = a[31]; nb = b[31];
								ma = na ? -a : a; mb = nb ? -b : b;
								q = ma / mb; rm = ma % mb;
								lo_q = (na != nb) ? -q : q;
								hi_q = na ? -rm : rm;
							end
							FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
							FN_ADD, FN_ADDU: begin wen = 1; widx = rd; wval = a + b; end
							FN_SUB, FN_SUBU: begin wen = 1; widx = rd; wval = a - b; end
							FN_AND:  begin wen = 1; widx = rd; wval = a & b; end
							FN_OR:   begin wen = 1; widx = rd; wval = a | b; end
							FN_XOR:  begin wen = 1; widx = rd; wval = a ^ b; end
							FN_NOR:  begin wen = 1; widx = rd; wval = ~(a | b); end
							FN_SLT: begin
								wen = 1; widx = rd; wval = {31'b0, $signed(a) < $signed(b)};
							end
							FN_SLTU: begin wen = 1; widx = rd; wval = {31'b0, a < b}; end
							default: begin r.status = ST_UNSUP; halted_q = 1'b1; end
						endcase
					end
					OP_REGIMM: begin
						case (rt)
							RI_BLTZ: if (a[31]) pc_q = btgt;
							RI_BGEZ: if (!a[31]) pc_q = btgt;
							RI_BLTZAL: begin
								if (a[31]) pc_q = btgt;
								wen = 1; widx = 5'd31; wval = pcn;
							end
							RI_BGEZAL: begin
								if (!a[31]) pc_q = btgt;
								wen = 1; widx = 5'd31; wval = pcn;
							end
							default: begin r.status = ST_UNSUP; halted_q = 1'b1; end
						endcase
					end
					OP_J: pc_q = {pcn[31:28], it.instr[25:0], 2'b00};
					OP_JAL: begin
						pc_q = {pcn[31:28], it.instr[25:0], 2'b00};
						wen = 1; widx = 5'd31; wval = pcn;
					end
					OP_BEQ:  if (a == b) pc_q = btgt;
					OP_BNE:  if (a != b) pc_q = btgt;
					OP_BLEZ: if (a[31] || a == 0) pc_q = btgt;
					OP_BGTZ: if (!a[31] && a != 0) pc_q = btgt;
					OP_ADDI, OP_ADDIU: begin wen = 1; widx = rt; wval = a + simm; end
					OP_SLTI: begin
						wen = 1; widx = rt; wval = {31'b0, $signed(a) < $signed(simm)};
					end
					OP_SLTIU: begin wen = 1; widx = rt; wval = {31'b0, a < simm}; end
					OP_ANDI: begin wen = 1; widx = rt; wval = a & imm; end
					OP_ORI:  begin wen = 1; widx = rt; wval = a | imm; end
					OP_XORI: begin wen = 1; widx = rt; wval = a ^ imm; end
					OP_LUI:  begin wen = 1; widx = rt; wval = imm << 16; end
					OP_LLO:  begin wen = 1; widx = rt; wval = {b[31:16], imm[15:0]}; end
					OP_LHI:  begin wen = 1; widx = rt; wval = {imm[15:0], b[15:0]}; end
					OP_TRAP: begin r.status = ST_TRAP; halted_q = 1'b1; end
					OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
						case (op)
							OP_LB:   load_kind_q = LK_LB;
							OP_LH:   load_kind_q = LK_LH;
							OP_LW:   load_kind_q = LK_LW;
							OP_LBU:  load_kind_q = LK_LBU;
							default: load_kind_q = LK_LHU;
						endcase
						load_pend_q = 1'b1;
						load_dest_q = rt;
						r.mem_kind = MK_LOAD;
						r.mem_addr = addr;
						r.mem_size = (op == OP_LW) ? MS_WORD :
							(op == OP_LH || op == OP_LHU) ? MS_HALF : MS_BYTE;
						r.status = ST_LOAD;
					end
					OP_SB: begin
						r.mem_kind = MK_STORE; r.mem_addr = addr;
						r.mem_size = MS_BYTE; r.store_data = {24'b0, b[7:0]};
					end
					OP_SH: begin
						r.mem_kind = MK_STORE; r.mem_addr = addr;
						r.mem_size = MS_HALF; r.store_data = {16'b0, b[15:0]};
					end
					OP_SW: begin
						r.mem_kind = MK_STORE; r.mem_addr = addr;
						r.mem_size = MS_WORD; r.store_data = b;
					end
					default: begin r.status = ST_UNSUP; halted_q = 1'b1; end
				endcase
			end
		end
		// A write to r0 is dropped and not reported.
		if (wen && widx != 0) begin
			gpr[widx] = wval;
			r.wb_valid = 1'b1; r.wb_reg = widx; r.wb_value = wval;
		end
		r.next_pc = pc_q;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Shadow state, prediction on each input transfer, comparison on each result transfer.
	always @(posedge clk or negedge arst_n) begin
		result_t e, g;
		if (!arst_n) begin
			foreach (gpr[i]) gpr[i] = '0;
			hi_q = '0; lo_q = '0; pc_q = '0; top_q = MEM_TOP_RESET;
			halted_q = 1'b0; load_pend_q = 1'b0;
			load_dest_q = '0; load_kind_q = LK_LB;
			expected_results.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_START_PC) pc_q = cfg_data;
				else top_q = cfg_data;
			end
			if (in_ch.valid && in_ch.ready) begin
				e = execute_item(in_ch.data);
				expected_results = {expected_results, e};
			end
			if (out_ch.valid && out_ch.ready) begin
				g = out_ch.data;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, g);
					errors++;
				end else begin
					e = expected_results.pop_front();
					check_field("next_pc", e.next_pc, g.next_pc);
					check_field("mem_kind", e.mem_kind, g.mem_kind);
					check_field("mem_addr", e.mem_addr, g.mem_addr);
					check_field("mem_size", e.mem_size, g.mem_size);
					check_field("store_data", e.store_data, g.store_data);
					check_field("wb_valid", e.wb_valid, g.wb_valid);
					check_field("wb_reg", e.wb_reg, g.wb_reg);
					check_field("wb_value", e.wb_value, g.wb_value);
					check_field("status", e.status, g.status);
					check_field("syscall_service", e.syscall_service, g.syscall_service);
					check_field("syscall_arg", e.syscall_arg, g.syscall_arg);
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

### tb/tb_risc_integer_execute_unit_top.sv
module tb_risc_integer_execute_unit_top;
	import rieu_pkg::*;

	localparam int SETTLE = 40;
	localparam int WATCHDOG = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = CFG_START_PC;
	logic [31:0] cfg_data = '0;
	int          errors, outstanding, idle_cycles;
	int          stall_left;
	logic        fast_mode;
	logic        load_open;

	rieu_in_if  in_ch();
	rieu_out_if out_ch();

	risc_integer_execute_unit_top DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	rieu_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .outstanding(outstanding)
	);

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		stall_left = 0;
		fast_mode = 1'b0;
	end

	// Result side back-pressure: mostly short stalls, a few long ones, and fast stretches.
	always @(negedge clk) begin
		int roll;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 2) fast_mode <= ~fast_mode;
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (fast_mode || roll < 60) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= 1'b0;
			stall_left <= (roll < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
		end
	end

	// Watchdog on cycles without any transfer or register write.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG) begin
			$display("tb_risc_integer_execute_unit_top: errors");
			$finish;
		end
	end

	function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
		logic [4:0] sh, logic [5:0] fn);
		return {OP_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic is_load(logic [31:0] w);
		return w[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
	endfunction

	// One input transfer, with a random gap before it.
	task automatic send(logic f, logic [31:0] w, logic [31:0] ld);
		int gap;
		gap = ($urandom_range(0, 99) < 93) ? $urandom_range(0, 2) : $urandom_range(10, 40);
		repeat (gap) @(negedge clk);
		if (gap == 0 && !in_ch.valid) @(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= '{func: f, instr: w, load_word: ld};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (!f && !load_open && is_load(w)) load_open = 1'b1;
		else if (f) load_open = 1'b0;
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Waits until every result has arrived and the block has gone quiet.
	task automatic drain();
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
	endfunction

	// A random non-halting instruction with random register and immediate fields.
	function automatic logic [31:0] random_instr();
		logic [5:0]  fns [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
			FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
			FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
			FN_NOR, FN_SLT, FN_SLTU};
		logic [5:0]  ops [25] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI,
			OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LLO, OP_LHI,
			OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW, OP_REGIMM};
		logic [4:0]  ris [4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
		logic [15:0] imm;
		logic [5:0]  op;
		int          roll;
		roll = $urandom_range(0, 99);
		imm = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
		if (roll < 3) return '0;
		if (roll < 45)
			return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
				fns[$urandom_range(0, 26)]);
		op = ops[$urandom_range(0, 24)];
		if (op == OP_J || op == OP_JAL) return {op, 26'($urandom)};
		if (op == OP_REGIMM) return enc_i(op, pick_reg(), ris[$urandom_range(0, 3)], imm);
		return enc_i(op, pick_reg(), pick_reg(), imm);
	endfunction

	// Random program phase: well-formed load sequences, with some out-of-order noise.
	task automatic run_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (load_open) begin
				if ($urandom_range(0, 99) < 85) send(1'b1, $urandom, $urandom);
				else send(1'b0, $urandom, $urandom);
			end else if ($urandom_range(0, 99) < 3) begin
				send(1'b1, $urandom, $urandom);
			end else begin
				send(1'b0, random_instr(), $urandom);
			end
		end
	endtask

	initial begin
		logic [31:0] starts [6] = '{32'h0, 32'hFFFF_FFFC, 32'h100, 32'hFFFF_FFFF,
			32'h0040_0000, 32'h0};
		logic [31:0] tops [6] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FF, 32'h0,
			32'hFFFF_FFFF, 32'h0};
		load_open = 1'b0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, hi/lo corner cases, byte and unsigned halfword loads, ordering errors.
		send(1'b0, 32'h0, 32'h0);
		send(1'b0, enc_i(OP_ADDIU, 5'd0, 5'd1, 16'hFFFF), '0);
		send(1'b0, enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000), '0);
		send(1'b0, enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h1234), '0);
		send(1'b0, enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD), '0);
		send(1'b0, enc_r(5'd2, 5'd1, 5'd4, 5'd0, FN_SUB), '0);
		send(1'b0, enc_r(5'd0, 5'd2, 5'd5, 5'd31, FN_SRA), '0);
		send(1'b0, enc_r(5'd1, 5'd2, 5'd6, 5'd0, FN_SRAV), '0);
		send(1'b0, enc_r(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT), '0);
		send(1'b0, enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_MULTU), '0);
		send(1'b0, enc_r(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV), '0);
		send(1'b0, enc_r(5'd2, 5'd1, 5'd0, 5'd0, FN_DIV), '0);
		send(1'b0, enc_r(5'd0, 5'd0, 5'd7, 5'd0, FN_MFHI), '0);
		send(1'b0, enc_r(5'd0, 5'd0, 5'd8, 5'd0, FN_MFLO), '0);
		send(1'b0, enc_r(5'd2, 5'd3, 5'd0, 5'd0, FN_DIVU), '0);
		send(1'b0, enc_i(OP_SLTIU, 5'd2, 5'd9, 16'hFFFF), '0);
		send(1'b0, enc_i(OP_LLO, 5'd0, 5'd2, 16'hBEEF), '0);
		send(1'b0, enc_i(OP_LHI, 5'd0, 5'd1, 16'h0000), '0);
		send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(1'b0, enc_i(OP_LB, 5'd2, 5'd10, 16'h8000), '0);
		send(1'b0, 32'hFFFF_FFFF, '0);
		send(1'b1, '0, 32'h80FF_FFFF);
		send(1'b0, enc_i(OP_LHU, 5'd1, 5'd11, 16'h7FFF), '0);
		send(1'b1, '0, 32'h8001_0000);
		send(1'b0, enc_i(OP_SH, 5'd2, 5'd10, 16'hFFFE), '0);
		send(1'b0, enc_i(OP_REGIMM, 5'd0, RI_BLTZAL, 16'h0010), '0);
		send(1'b0, enc_r(5'd31, 5'd0, 5'd31, 5'd0, FN_JALR), '0);
		send(1'b0, enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL), '0);

		// Random phases under several program counter and wrap settings.
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(CFG_START_PC, (ph == 5) ? $urandom : starts[ph]);
			write_reg(CFG_MEMORY_TOP, (ph == 5) ? $urandom : tops[ph]);
			run_phase(80);
		end

		// Finally one halting instruction; afterwards everything reports halted.
		drain();
		case ($urandom_range(0, 2))
			0: send(1'b0, enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_BREAK), '0);
			1: send(1'b0, enc_i(OP_TRAP, 5'd0, 5'd0, 16'h0), '0);
			default: send(1'b0, enc_i(6'h3F, 5'd0, 5'd0, 16'h0), '0);
		endcase
		send(1'b0, enc_i(OP_ADDIU, 5'd0, 5'd1, 16'h1), '0);
		drain();
		write_reg(CFG_START_PC, 32'h44);
		send(1'b1, '0, $urandom);
		drain();

		if (errors == 0) begin
			$display("tb_risc_integer_execute_unit_top: clean");
		end else begin
			$display("tb_risc_integer_execute_unit_top: errors");
		end
		$finish;
	end

endmodule

### risc_integer_execute_unit_top.f
sv/rieu_pkg.sv
sv/rieu_if.sv
sv/rieu_divider.sv
sv/rieu_datapath.sv
sv/rieu_control.sv
sv/risc_integer_execute_unit_top.sv
tb/rieu_checker.sv
tb/tb_risc_integer_execute_unit_top.sv
